@@ src/psac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psac_pkg
// Shared types and codes for the page span allocator: operation and status
// codes, controller states, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package psac_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK,
    S_U_RD, S_U_LINK, S_U_CLR, S_SPLIT_CHK, S_GRANT, S_MARK,
    S_P_RD, S_P_LINK, S_P_BACK,
    S_F_HEAD, S_F_LEN, S_F_NEXT_CHK, S_F_PREV, S_F_PREV_CHK, S_F_ADD, S_F_MERGE,
    S_OUT
  } state_t;

  // what the current unlink / mark / push sequence is working on
  typedef enum logic [2:0] {
    PH_TAKE, PH_SPLIT, PH_GRANT, PH_NEXT, PH_PREV, PH_MERGE
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_NEXT, OP_TAKE,
    OP_U_RD, OP_U_LINK, OP_U_CLR,
    OP_MARK_SPLIT, OP_MARK_GRANT, OP_MARK_FREE, OP_MARK_STEP,
    OP_P_RD, OP_P_LINK, OP_P_BACK,
    OP_RD_PAGE, OP_F_HEAD, OP_F_LEN, OP_TGT_PI, OP_RD_PREV,
    OP_ADD_NEXT, OP_ADD_PREV, OP_OUT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic func_free;
    logic bad_count;
    logic bad_page;
    logic clr_last;
    logic scan_hit;
    logic scan_last;
    logic pi_free;
    logic q_ok;
    logic split_ok;
    logic prev_above;
    logic mark_last;
    logic out_free;
  } sts_t;

endpackage

@@ src/psac_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psac_ctrl
// Sequencer for the allocator: clearing pass, list scan, unlink, page
// marking, push, neighbour checks on free and result hand-off, one datapath command per cycle.
// ----------------------------------------------------------------------------
module psac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  psac_pkg::sts_t  sts,
  output psac_pkg::cmd_t  cmd
);
  import psac_pkg::*;

  state_t  state, state_next;
  phase_t  ph, ph_next;
  status_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ph    <= PH_TAKE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    ph_next    = ph;
    code_next  = code;
    cmd.op     = OP_NONE;
    cmd.code   = code;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func_free) begin
          if (sts.bad_page) begin
            code_next  = ST_BAD_FREE;
            state_next = S_OUT;
          end else begin
            cmd.op     = OP_RD_PAGE;
            state_next = S_F_HEAD;
          end
        end else if (sts.bad_count) begin
          code_next  = ST_BAD_COUNT;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_SCAN_INIT;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.op     = OP_SCAN_RD;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.scan_hit) begin
          cmd.op     = OP_TAKE;
          ph_next    = PH_TAKE;
          state_next = S_U_RD;
        end else if (sts.scan_last) begin
          code_next  = ST_OOM;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_SCAN_NEXT;
          state_next = S_SCAN_RD;
        end
      end
      S_U_RD: begin
        cmd.op     = OP_U_RD;
        state_next = S_U_LINK;
      end
      S_U_LINK: begin
        cmd.op     = OP_U_LINK;
        state_next = S_U_CLR;
      end
      S_U_CLR: begin
        cmd.op     = OP_U_CLR;
        state_next = (ph == PH_TAKE) ? S_SPLIT_CHK : S_F_ADD;
      end
      S_SPLIT_CHK: begin
        state_next = S_MARK;
        if (sts.split_ok) begin
          cmd.op  = OP_MARK_SPLIT;
          ph_next = PH_SPLIT;
        end else begin
          cmd.op  = OP_MARK_GRANT;
          ph_next = PH_GRANT;
        end
      end
      S_GRANT: begin
        cmd.op     = OP_MARK_GRANT;
        ph_next    = PH_GRANT;
        state_next = S_MARK;
      end
      S_MARK: begin
        cmd.op = OP_MARK_STEP;
        if (sts.mark_last) begin
          if (ph == PH_GRANT) begin
            code_next  = ST_OK;
            state_next = S_OUT;
          end else begin
            state_next = S_P_RD;
          end
        end
      end
      S_P_RD: begin
        cmd.op     = OP_P_RD;
        state_next = S_P_LINK;
      end
      S_P_LINK: begin
        cmd.op     = OP_P_LINK;
        state_next = S_P_BACK;
      end
      S_P_BACK: begin
        cmd.op = OP_P_BACK;
        if (ph == PH_SPLIT) begin
          state_next = S_GRANT;
        end else begin
          code_next  = ST_OK;
          state_next = S_OUT;
        end
      end
      S_F_HEAD: begin
        if (sts.pi_free) begin
          code_next  = ST_BAD_FREE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_F_HEAD;
          state_next = S_F_LEN;
        end
      end
      S_F_LEN: begin
        cmd.op     = OP_F_LEN;
        state_next = S_F_NEXT_CHK;
      end
      S_F_NEXT_CHK: begin
        if (sts.q_ok && sts.pi_free) begin
          cmd.op     = OP_TGT_PI;
          ph_next    = PH_NEXT;
          state_next = S_U_RD;
        end else begin
          state_next = S_F_PREV;
        end
      end
      S_F_PREV: begin
        if (sts.prev_above) begin
          cmd.op     = OP_RD_PREV;
          state_next = S_F_PREV_CHK;
        end else begin
          state_next = S_F_MERGE;
        end
      end
      S_F_PREV_CHK: begin
        if (sts.pi_free) begin
          cmd.op     = OP_TGT_PI;
          ph_next    = PH_PREV;
          state_next = S_U_RD;
        end else begin
          state_next = S_F_MERGE;
        end
      end
      S_F_ADD: begin
        if (ph == PH_PREV) begin
          cmd.op     = OP_ADD_PREV;
          state_next = S_F_MERGE;
        end else begin
          cmd.op     = OP_ADD_NEXT;
          state_next = S_F_PREV;
        end
      end
      S_F_MERGE: begin
        cmd.op     = OP_MARK_FREE;
        ph_next    = PH_MERGE;
        state_next = S_MARK;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/psac_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psac_dp
// Datapath: page descriptor, span length, link and list head memories,
// working registers and the output register.
// ----------------------------------------------------------------------------
module psac_dp #(
  parameter int POOL_PAGES     = 512,
  parameter int RESERVED_PAGES = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  psac_pkg::cmd_t  cmd,
  output psac_pkg::sts_t  sts,
  input  logic            func,
  input  logic [9:0]      page_count,
  input  logic [8:0]      block_page,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [8:0]      start_page,
  output logic [9:0]      span_pages
);
  import psac_pkg::*;

  localparam int AW     = $clog2(POOL_PAGES);
  localparam int LW     = $clog2(POOL_PAGES + 1);
  localparam int LW1    = LW + 1;
  localparam int CW     = (LW > 10) ? LW : 10;
  localparam int USABLE = POOL_PAGES - RESERVED_PAGES;
  localparam logic [LW-1:0] NIL        = LW'(POOL_PAGES);
  localparam logic [AW-1:0] LAST       = AW'(POOL_PAGES - 1);
  localparam logic [AW-1:0] FIRST      = AW'(RESERVED_PAGES);
  localparam logic [AW-1:0] TOP_LIST   = AW'(USABLE - 1);
  localparam logic [LW-1:0] USABLE_LEN = LW'(USABLE);

  typedef struct packed {
    logic          used;
    logic [AW-1:0] head;
  } pinfo_t;

  pinfo_t        pi_mem [POOL_PAGES];
  logic [LW-1:0] sl_mem [POOL_PAGES];
  logic [LW-1:0] sn_mem [POOL_PAGES];
  logic [LW-1:0] sp_mem [POOL_PAGES];
  logic [LW-1:0] lh_mem [POOL_PAGES];

  pinfo_t        pi_rd, pi_wd;
  logic [LW-1:0] sl_rd, sn_rd, sp_rd, lh_rd;
  logic [LW-1:0] sl_wd, sn_wd, sp_wd, lh_wd;
  logic          pi_we, sl_we, sn_we, sp_we, lh_we;
  logic [AW-1:0] pi_wa, sl_wa, sn_wa, sp_wa, lh_wa;
  logic [AW-1:0] pi_ra, sl_ra, link_ra, lh_ra;

  // working registers
  logic          func_r;
  logic [CW-1:0] n_r, pg_r;
  logic [AW-1:0] k_r, h_r, tgt, mstart;
  logic [LW-1:0] len_r, ulen, old_r, mlen, mp;
  logic [LW1-1:0] q_r;
  logic          uok, mused;

  logic [LW1-1:0] mend, mp_inc, hn, qsum;
  logic          uguard, pguard, res_ok;

  assign mend   = LW1'(mstart) + LW1'(mlen);
  assign mp_inc = LW1'(mp) + LW1'(1);
  assign hn     = LW1'(h_r) + LW1'(n_r);
  assign qsum   = LW1'(h_r) + LW1'(sl_rd);
  assign uguard = (sl_rd != '0) && (sl_rd <= NIL);
  assign pguard = (mlen != '0) && (mlen <= NIL);
  assign res_ok = (cmd.code == ST_OK);

  always_comb begin
    sts.func_free  = (func_r == FUNC_FREE);
    sts.bad_count  = (n_r == '0) || (n_r > CW'(POOL_PAGES));
    sts.bad_page   = (pg_r >= CW'(POOL_PAGES)) || (pg_r < CW'(RESERVED_PAGES));
    sts.clr_last   = (k_r == LAST);
    sts.scan_hit   = (lh_rd != NIL);
    sts.scan_last  = (k_r == LAST);
    sts.pi_free    = !pi_rd.used;
    sts.q_ok       = (q_r < LW1'(POOL_PAGES));
    sts.split_ok   = (ulen > LW'(n_r)) && (hn < LW1'(POOL_PAGES));
    sts.prev_above = (h_r > FIRST);
    sts.mark_last  = (mp_inc >= mend) || (mp_inc >= LW1'(POOL_PAGES));
    sts.out_free   = !out_valid || !out_stall;
  end

  // memory port control
  always_comb begin
    pi_we   = 1'b0;
    pi_wa   = mp[AW-1:0];
    pi_wd   = '{used: mused, head: mstart};
    pi_ra   = pg_r[AW-1:0];
    sl_we   = 1'b0;
    sl_wa   = mstart;
    sl_wd   = mlen;
    sl_ra   = tgt;
    sn_we   = 1'b0;
    sn_wa   = tgt;
    sn_wd   = NIL;
    sp_we   = 1'b0;
    sp_wa   = tgt;
    sp_wd   = NIL;
    link_ra = tgt;
    lh_we   = 1'b0;
    lh_wa   = AW'(mlen - LW'(1));
    lh_wd   = LW'(mstart);
    lh_ra   = k_r;
    case (cmd.op)
      OP_CLEAR: begin
        pi_we = 1'b1;
        pi_wa = k_r;
        pi_wd = (k_r < FIRST) ? '{used: 1'b1, head: k_r} : '{used: 1'b0, head: FIRST};
        sl_we = 1'b1;
        sl_wa = k_r;
        sl_wd = (k_r == FIRST) ? USABLE_LEN : '0;
        sn_we = 1'b1;
        sn_wa = k_r;
        sp_we = 1'b1;
        sp_wa = k_r;
        lh_we = 1'b1;
        lh_wa = k_r;
        lh_wd = (k_r == TOP_LIST) ? LW'(FIRST) : NIL;
      end
      OP_F_HEAD:  sl_ra = pi_rd.head;
      OP_F_LEN:   pi_ra = qsum[AW-1:0];
      OP_RD_PREV: pi_ra = h_r - AW'(1);
      OP_P_RD:    lh_ra = AW'(mlen - LW'(1));
      OP_U_LINK: begin
        if (uguard) begin
          if (sp_rd != NIL) begin
            sn_we = 1'b1;
            sn_wa = sp_rd[AW-1:0];
            sn_wd = sn_rd;
          end else begin
            lh_we = 1'b1;
            lh_wa = AW'(sl_rd - LW'(1));
            lh_wd = sn_rd;
          end
          if (sn_rd != NIL) begin
            sp_we = 1'b1;
            sp_wa = sn_rd[AW-1:0];
            sp_wd = sp_rd;
          end
        end
      end
      OP_U_CLR: begin
        sn_we = uok;
        sp_we = uok;
      end
      OP_MARK_STEP: begin
        pi_we = 1'b1;
        sl_we = 1'b1;
      end
      OP_P_LINK: begin
        if (pguard) begin
          sn_we = 1'b1;
          sn_wa = mstart;
          sn_wd = lh_rd;
          sp_we = 1'b1;
          sp_wa = mstart;
          lh_we = 1'b1;
        end
      end
      OP_P_BACK: begin
        if (pguard && (old_r != NIL)) begin
          sp_we = 1'b1;
          sp_wa = old_r[AW-1:0];
          sp_wd = LW'(mstart);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pi_we) pi_mem[pi_wa] <= pi_wd;
    pi_rd <= pi_mem[pi_ra];
  end

  always_ff @(posedge clk) begin
    if (sl_we) sl_mem[sl_wa] <= sl_wd;
    sl_rd <= sl_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (sn_we) sn_mem[sn_wa] <= sn_wd;
    sn_rd <= sn_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (sp_we) sp_mem[sp_wa] <= sp_wd;
    sp_rd <= sp_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (lh_we) lh_mem[lh_wa] <= lh_wd;
    lh_rd <= lh_mem[lh_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        OP_CLEAR:     k_r <= k_r + AW'(1);
        OP_LOAD: begin
          func_r <= func;
          n_r    <= CW'(page_count);
          pg_r   <= CW'(block_page);
        end
        OP_SCAN_INIT: k_r <= AW'(n_r - CW'(1));
        OP_SCAN_NEXT: k_r <= k_r + AW'(1);
        OP_TAKE: begin
          h_r <= lh_rd[AW-1:0];
          tgt <= lh_rd[AW-1:0];
        end
        OP_U_LINK: begin
          ulen <= sl_rd;
          uok  <= uguard;
        end
        OP_MARK_SPLIT: begin
          mstart <= hn[AW-1:0];
          mp     <= hn[LW-1:0];
          mlen   <= ulen - LW'(n_r);
          mused  <= 1'b0;
        end
        OP_MARK_GRANT: begin
          mstart <= h_r;
          mp     <= LW'(h_r);
          mlen   <= LW'(n_r);
          len_r  <= LW'(n_r);
          mused  <= 1'b1;
        end
        OP_MARK_FREE: begin
          mstart <= h_r;
          mp     <= LW'(h_r);
          mlen   <= len_r;
          mused  <= 1'b0;
        end
        OP_MARK_STEP: mp <= mp + LW'(1);
        OP_P_LINK:    old_r <= lh_rd;
        OP_F_HEAD:    h_r <= pi_rd.head;
        OP_F_LEN: begin
          len_r <= sl_rd;
          q_r   <= qsum;
        end
        OP_TGT_PI:    tgt <= pi_rd.head;
        OP_ADD_NEXT:  len_r <= len_r + ulen;
        OP_ADD_PREV: begin
          len_r <= len_r + ulen;
          h_r   <= tgt;
        end
        OP_OUT: begin
          status     <= cmd.code;
          start_page <= res_ok ? 9'(h_r) : '0;
          span_pages <= res_ok ? 10'(len_r) : '0;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/page_span_allocator_coalescing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_span_allocator_coalescing
// Page span allocator with per-length free lists, span splitting on
// allocate and merging with free neighbours on free.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | func, page_count, block_page
//  out     | output    | out_valid/out_stall | status, start_page, span_pages
//
//  After reset a clearing pass writes every memory entry with in_stall
//  high. One item is worked on at a time over memories with one write and
//  one read port, one page descriptor written per cycle while marking:
//  allocate scans the size lists from the requested length up, unlinks
//  the span found, splits off and pushes any remainder and marks the
//  granted pages. Free merges the span with a free neighbour after and
//  before it and marks and pushes the merged span. The next item is taken
//  while a result waits under out_stall.
// ----------------------------------------------------------------------------
module page_span_allocator_coalescing #(
  parameter int POOL_PAGES     = 512,
  parameter int RESERVED_PAGES = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [9:0] page_count,
  input  logic [8:0] block_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [8:0] start_page,
  output logic [9:0] span_pages
);
  import psac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psac_dp #(
    .POOL_PAGES     (POOL_PAGES),
    .RESERVED_PAGES (RESERVED_PAGES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func       (func),
    .page_count (page_count),
    .block_page (block_page),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .start_page (start_page),
    .span_pages (span_pages)
  );

endmodule

@@ src/psac_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psac_checker
// Port-level checks for the page span allocator, bound to the top level.
// ----------------------------------------------------------------------------
module psac_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       func,
  input logic [9:0] page_count,
  input logic [8:0] block_page,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [8:0] start_page,
  input logic [9:0] span_pages
);

  // clearing pass keeps the input closed straight after reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open right after reset");

  // one item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input still open after accepting an item");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != psac_pkg::ST_OK)) |-> (start_page == '0 && span_pages == '0))
    else $error("error result with non-zero span fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(start_page) && $stable(span_pages)))
    else $error("stalled result changed");

endmodule

bind page_span_allocator_coalescing psac_checker u_psac_checker (.*);
